FILE: rtl/core/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// AES-256 CTR keystream package
// S-box table, GF(2^8) doubling, round function and key-schedule helpers.
// ----------------------------------------------------------------------------
package aesctr_pkg;

    localparam int unsigned NUM_ROUNDS = 14;
    localparam int unsigned NUM_RKEYS  = 15;

    typedef logic [127:0] t_block;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_KEY0  = 3'd0,
        REG_KEY1  = 3'd1,
        REG_KEY2  = 3'd2,
        REG_KEY3  = 3'd3,
        REG_NONCE = 3'd4
    } t_reg_idx;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte k of the state sits at bits [8k+7:8k] (little-endian layout)
    function automatic t_block aes_round(input t_block s, input t_block rk,
                                         input logic last);
        t_block t;
        logic [7:0] a0, a1, a2, a3, x;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[(c*4+r)*8 +: 8] = sbox(s[(((c + r) % 4)*4 + r)*8 +: 8]);
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[(c*4)*8 +: 8];
                a1 = t[(c*4+1)*8 +: 8];
                a2 = t[(c*4+2)*8 +: 8];
                a3 = t[(c*4+3)*8 +: 8];
                x  = a0 ^ a1 ^ a2 ^ a3;
                t[(c*4)*8 +: 8]   = a0 ^ x ^ gf_dbl(a0 ^ a1);
                t[(c*4+1)*8 +: 8] = a1 ^ x ^ gf_dbl(a1 ^ a2);
                t[(c*4+2)*8 +: 8] = a2 ^ x ^ gf_dbl(a2 ^ a3);
                t[(c*4+3)*8 +: 8] = a3 ^ x ^ gf_dbl(a3 ^ a0);
            end
        end
        return t ^ rk;
    endfunction

    // One 256-bit key-schedule step: eight new words from the previous eight
    function automatic logic [255:0] key_step(input logic [255:0] kp,
                                              input logic [7:0] rcon);
        logic [255:0] kn;
        logic [31:0]  t, w;
        kn = '0;
        for (int j = 0; j < 8; j++) begin
            if (j == 0) begin
                w = kp[224 +: 32];
                t = {sbox(w[7:0]), sbox(w[31:24]), sbox(w[23:16]),
                     sbox(w[15:8]) ^ rcon};
            end else if (j == 4) begin
                w = kn[96 +: 32];
                t = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
            end else begin
                t = kn[(j-1)*32 +: 32];
            end
            kn[j*32 +: 32] = kp[j*32 +: 32] ^ t;
        end
        return kn;
    endfunction

endpackage

FILE: rtl/core/aesctr_pipe.sv
// ----------------------------------------------------------------------------
// AES-256 round pipeline
// Fifteen register stages: the initial key add, then one AES round each.
// ----------------------------------------------------------------------------
module aesctr_pipe
    import aesctr_pkg::*;
#(
    parameter int TAG_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  t_block               i_block,
    input  logic [TAG_W-1:0]     i_tag,
    input  t_block               i_rkeys [NUM_RKEYS],
    output logic                 o_valid,
    output t_block               o_block,
    output logic [TAG_W-1:0]     o_tag
);

    logic               r_vld [NUM_RKEYS];
    t_block             r_st  [NUM_RKEYS];
    logic [TAG_W-1:0]   r_tag [NUM_RKEYS];

    // The whole pipe moves as one while the output is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_RKEYS; k++) r_vld[k] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NUM_RKEYS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st[0]  <= i_block ^ i_rkeys[0];
            r_tag[0] <= i_tag;
            for (int k = 1; k < NUM_RKEYS; k++) begin
                r_st[k]  <= aes_round(r_st[k-1], i_rkeys[k], k == NUM_ROUNDS);
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_vld[NUM_RKEYS-1];
    assign o_block = r_st[NUM_RKEYS-1];
    assign o_tag   = r_tag[NUM_RKEYS-1];

endmodule

FILE: rtl/core/aes256_ctr_keystream_core.sv
// ----------------------------------------------------------------------------
// AES-256 CTR keystream core
// Expands each counter request into a run of encrypted counter blocks.
// ----------------------------------------------------------------------------
// channel   | direction | handshake            | payload
// request   | in        | i_valid / o_stall    | i_counter_base
// result    | out       | o_valid / i_stall    | o_block_index, o_cipher_low/high,
//           |           |                      | o_last_block
// config    | in        | APB psel/penable     | paddr, pwdata, prdata
//
// One request yields BLOCKS_PER_ITEM results, one per cycle while the result
// stall does not hold the pipe; a new request is taken when idle or while the
// last block of a run issues, set by the single counter issue stage. Round keys
// are expanded in the background after any register write. Reset clears keys,
// nonce, issue state, all valid bits; i_stall with o_valid holds the whole pipe.
// ----------------------------------------------------------------------------
module aes256_ctr_keystream_core
    import aesctr_pkg::*;
#(
    parameter int BLOCKS_PER_ITEM = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [63:0]   i_counter_base,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [2:0]    o_block_index,
    output logic [63:0]   o_cipher_low,
    output logic [63:0]   o_cipher_high,
    output logic          o_last_block,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    localparam int CNT_W = (BLOCKS_PER_ITEM > 1) ? $clog2(BLOCKS_PER_ITEM) : 1;
    localparam int TAG_W = CNT_W + 1;

    logic [63:0] r_key [4];
    logic [63:0] r_nonce;
    logic [2:0]  w_ridx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_ridx = paddr[5:3];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            r_nonce <= '0;
        end else if (w_wr) begin
            case (w_ridx)
                REG_KEY0:  r_key[0] <= pwdata;
                REG_KEY1:  r_key[1] <= pwdata;
                REG_KEY2:  r_key[2] <= pwdata;
                REG_KEY3:  r_key[3] <= pwdata;
                REG_NONCE: r_nonce  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_ridx)
            REG_KEY0:  prdata = r_key[0];
            REG_KEY1:  prdata = r_key[1];
            REG_KEY2:  prdata = r_key[2];
            REG_KEY3:  prdata = r_key[3];
            REG_NONCE: prdata = r_nonce;
            default:   prdata = '0;
        endcase
    end

    // Key schedule: one 256-bit step a cycle, restarted on any write
    logic [255:0] r_kw [1:7];
    logic [255:0] w_kw [8];
    logic [2:0]   r_kstep;
    logic [7:0]   r_rcon;
    t_block       w_rk [NUM_RKEYS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_wr) begin
            r_kstep <= 3'd1;
            r_rcon  <= 8'h01;
        end else if (r_kstep != 3'd0) begin
            r_kw[r_kstep] <= key_step(w_kw[r_kstep - 3'd1], r_rcon);
            r_rcon        <= gf_dbl(r_rcon);
            r_kstep       <= (r_kstep == 3'd7) ? 3'd0 : r_kstep + 3'd1;
        end
    end

    always_comb begin
        w_kw[0] = {r_key[3], r_key[2], r_key[1], r_key[0]};
        for (int k = 1; k < 8; k++) w_kw[k] = r_kw[k];
    end

    always_comb begin
        for (int k = 0; k < NUM_RKEYS; k++) begin
            w_rk[k] = w_kw[k/2][(k%2)*128 +: 128];
        end
    end

    // Issue stage: walk the counter through the run
    logic              r_busy;
    logic [63:0]       r_ctr;
    logic [CNT_W-1:0]  r_idx;
    logic              w_adv, w_last_iss;
    logic              p_vld;
    t_block            p_blk;
    logic [TAG_W-1:0]  p_tag;

    assign w_adv      = ~(o_valid & i_stall);
    assign w_last_iss = (r_idx == CNT_W'(BLOCKS_PER_ITEM - 1));
    // take the next request while the last block of the run issues
    assign o_stall    = (r_busy & ~w_last_iss) | ~w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_adv) begin
            if (r_busy && !w_last_iss) begin
                r_ctr  <= r_ctr + 64'd1;
                r_idx  <= r_idx + CNT_W'(1);
            end else if (i_valid) begin
                r_ctr  <= i_counter_base;
                r_idx  <= '0;
                r_busy <= 1'b1;
            end else begin
                r_idx  <= '0;
                r_busy <= 1'b0;
            end
        end
    end

    aesctr_pipe #(.TAG_W(TAG_W)) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_busy),
        .i_block ({r_nonce, r_ctr}),
        .i_tag   ({w_last_iss, r_idx}),
        .i_rkeys (w_rk),
        .o_valid (p_vld),
        .o_block (p_blk),
        .o_tag   (p_tag)
    );

    assign o_valid       = p_vld;
    assign o_cipher_low  = p_blk[63:0];
    assign o_cipher_high = p_blk[127:64];
    assign o_block_index = 3'(p_tag[CNT_W-1:0]);
    assign o_last_block  = p_tag[TAG_W-1];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cipher_low))
        else $error("result changed under stall");
    a_first_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_busy && r_idx == '0)
        else $error("run did not start at index zero");
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !w_last_iss |-> o_stall)
        else $error("request taken mid-run");

endmodule

FILE: tb/aes256_ctr_keystream_checker.sv
// ----------------------------------------------------------------------------
// AES-256 CTR keystream checker
// Watches the register port and both streams. It keeps its own copy of the
// key and nonce, computes the eight keystream blocks of every accepted
// request and compares each returned block with the oldest one waiting.
// ----------------------------------------------------------------------------
module aes256_ctr_keystream_checker
    import aesctr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_o_stall,
    input  logic [63:0] i_counter_base,
    input  logic        i_o_valid,
    input  logic        i_stall,
    input  logic [2:0]  i_block_index,
    input  logic [63:0] i_cipher_low,
    input  logic [63:0] i_cipher_high,
    input  logic        i_last_block,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LEN = 8;

    typedef struct {
        bit [2:0]  index;
        bit [63:0] low;
        bit [63:0] high;
        bit        last;
    } t_keyblock;

    t_keyblock  keyblock_q[$];
    bit [63:0]  key_word[4];
    bit [63:0]  nonce;
    bit [7:0]   sub_tab[256];
    bit [7:0]   round_key[240];

    function automatic bit [7:0] xtime(bit [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic bit [7:0] gmul(bit [7:0] a, bit [7:0] b);
        bit [7:0] p;
        p = 0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = xtime(a);
        end
        return p;
    endfunction

    function automatic bit [7:0] rotl(bit [7:0] x, int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    // Build the substitution table from the field inverse and the affine map
    initial begin
        bit [7:0] inv;
        for (int a = 0; a < 256; a++) begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++) inv = gmul(inv, a[7:0]);
            if (a == 0) inv = 0;
            sub_tab[a] = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3)
                         ^ rotl(inv, 4) ^ 8'h63;
        end
    end

    function automatic void expand_schedule();
        bit [7:0] t[4];
        bit [7:0] rc;
        bit [7:0] r0;
        rc = 8'h01;
        for (int k = 0; k < 32; k++) round_key[k] = key_word[k / 8][(k % 8) * 8 +: 8];
        for (int w = 8; w < 60; w++) begin
            for (int k = 0; k < 4; k++) t[k] = round_key[(w - 1) * 4 + k];
            if ((w & 7) == 0) begin
                r0   = t[0];
                t[0] = sub_tab[t[1]] ^ rc;
                t[1] = sub_tab[t[2]];
                t[2] = sub_tab[t[3]];
                t[3] = sub_tab[r0];
                rc   = xtime(rc);
            end else if ((w & 7) == 4) begin
                for (int k = 0; k < 4; k++) t[k] = sub_tab[t[k]];
            end
            for (int k = 0; k < 4; k++)
                round_key[w * 4 + k] = round_key[(w - 8) * 4 + k] ^ t[k];
        end
    endfunction

    function automatic bit [127:0] encrypt(bit [127:0] pt);
        bit [7:0] st[16];
        bit [7:0] t[16];
        bit [7:0] a0, a1, a2, a3, x;
        bit [127:0] ct;
        for (int k = 0; k < 16; k++) st[k] = pt[k * 8 +: 8] ^ round_key[k];
        for (int rnd = 1; rnd <= 14; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[c * 4 + r] = sub_tab[st[((c + r) & 3) * 4 + r]];
            if (rnd < 14) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[c * 4];     a1 = t[c * 4 + 1];
                    a2 = t[c * 4 + 2]; a3 = t[c * 4 + 3];
                    x  = a0 ^ a1 ^ a2 ^ a3;
                    t[c * 4]     = a0 ^ x ^ xtime(a0 ^ a1);
                    t[c * 4 + 1] = a1 ^ x ^ xtime(a1 ^ a2);
                    t[c * 4 + 2] = a2 ^ x ^ xtime(a2 ^ a3);
                    t[c * 4 + 3] = a3 ^ x ^ xtime(a3 ^ a0);
                end
            end
            for (int k = 0; k < 16; k++) st[k] = t[k] ^ round_key[rnd * 16 + k];
        end
        for (int k = 0; k < 16; k++) ct[k * 8 +: 8] = st[k];
        return ct;
    endfunction

    function automatic void predict_keystream(bit [63:0] base);
        t_keyblock kb;
        bit [127:0] ct;
        expand_schedule();
        for (int i = 0; i < RUN_LEN; i++) begin
            // counter wraps modulo 2^64
            ct       = encrypt({nonce, base + 64'(i)});
            kb.index = 3'(i);
            kb.low   = ct[63:0];
            kb.high  = ct[127:64];
            kb.last  = (i == RUN_LEN - 1);
            keyblock_q.push_back(kb);
        end
    endfunction

    task automatic report_mismatch(string what, bit [63:0] got, bit [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        key_word     = '{default: '0};
        nonce        = 0;
    end

    always @(posedge i_clk) begin
        t_keyblock kb;
        if (!i_rst_n) begin
            key_word = '{default: '0};
            nonce    = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0) begin
                case (paddr[5:3])
                    REG_KEY0:  key_word[0] = pwdata;
                    REG_KEY1:  key_word[1] = pwdata;
                    REG_KEY2:  key_word[2] = pwdata;
                    REG_KEY3:  key_word[3] = pwdata;
                    REG_NONCE: nonce       = pwdata;
                    default: ;  // drop writes beyond the register map
                endcase
            end
            if (i_valid && !i_o_stall) predict_keystream(i_counter_base);
            if (i_o_valid && !i_stall) begin
                if (keyblock_q.size() == 0) begin
                    report_mismatch("unexpected block", i_cipher_low, 0);
                end else begin
                    kb = keyblock_q.pop_front();
                    if (i_block_index != kb.index)
                        report_mismatch("block_index", i_block_index, kb.index);
                    if (i_cipher_low != kb.low)
                        report_mismatch("cipher_low", i_cipher_low, kb.low);
                    if (i_cipher_high != kb.high)
                        report_mismatch("cipher_high", i_cipher_high, kb.high);
                    if (i_last_block != kb.last)
                        report_mismatch("last_block", i_last_block, kb.last);
                end
            end
            o_pending = keyblock_q.size();
        end
    end

endmodule

FILE: tb/tb_aes256_ctr_keystream_core.sv
// ----------------------------------------------------------------------------
// AES-256 CTR keystream core testbench
// Drives counter requests and register writes over several key and nonce
// settings, stalls the result stream at random and takes the verdict from
// the checker's failure count.
// ----------------------------------------------------------------------------
module tb_aes256_ctr_keystream_core;
    import aesctr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] UNMAPPED_REG = 3'd5;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_counter_base;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_block_index;
    logic [63:0] o_cipher_low;
    logic [63:0] o_cipher_high;
    logic        o_last_block;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    aes256_ctr_keystream_core i_dut (.*);

    aes256_ctr_keystream_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .i_o_stall(o_stall), .i_counter_base,
        .i_o_valid(o_valid), .i_stall, .i_block_index(o_block_index),
        .i_cipher_low(o_cipher_low), .i_cipher_high(o_cipher_high),
        .i_last_block(o_last_block), .psel, .penable, .pwrite, .pready,
        .paddr, .pwdata, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("[aes256_ctr_keystream_core] ERROR");
        $finish;
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel = 1; pwrite = 1; penable = 0;
        paddr = {idx, 3'b000}; pwdata = value;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic send_request(bit [63:0] base, int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1;
        i_counter_base = base;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // hold requests back until every block is home, then let the key expand
    task automatic drain();
        @(negedge i_clk);
        i_valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        int hold;
        hold = 0;
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_stall = 0; hold = $urandom_range(0, 12);
                end else if (r < 95) begin
                    i_stall = 1; hold = $urandom_range(0, 3);
                end else begin
                    i_stall = 1; hold = $urandom_range(10, 50);
                end
            end
        end
    end

    initial begin
        bit [63:0] corner[7];
        i_rst_n = 0; i_valid = 0; i_counter_base = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;
        repeat (10) @(negedge i_clk);

        // counter extremes, including wrap inside a run
        corner = '{64'h0, '1, 64'hffff_ffff_ffff_fff8, 64'hffff_ffff_ffff_fff9,
                   64'h0000_0000_ffff_ffff, {16{4'ha}}, {16{4'h5}}};
        foreach (corner[k]) send_request(corner[k], pick_gap());
        drain();

        // all-ones key and nonce
        reg_write(REG_KEY0, '1);
        reg_write(REG_KEY1, '1);
        reg_write(REG_KEY2, '1);
        reg_write(REG_KEY3, '1);
        reg_write(REG_NONCE, '1);
        repeat (10) @(negedge i_clk);
        foreach (corner[k]) send_request(corner[k], 0);
        drain();

        // write beyond the register map must leave the settings alone
        reg_write(UNMAPPED_REG, 64'h0123_4567_89ab_cdef);
        repeat (10) @(negedge i_clk);
        send_request(64'h0, 0);
        send_request(rand64(), 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            reg_write(REG_KEY0, rand64());
            reg_write(REG_KEY1, rand64());
            reg_write(REG_KEY2, rand64());
            reg_write(REG_KEY3, rand64());
            reg_write(REG_NONCE, ph == 3 ? 64'h0 : rand64());
            repeat (10) @(negedge i_clk);
            for (int n = 0; n < 96; n++) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(64'hffff_ffff_ffff_ffff - $urandom_range(0, 9), pick_gap());
                else
                    send_request(rand64(), pick_gap());
            end
            drain();
        end

        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[aes256_ctr_keystream_core] OK");
        end else begin
            $display("[aes256_ctr_keystream_core] ERROR");
        end
        $finish;
    end

endmodule
